@@ rtl/brms_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, operation codes and mode constants for the banked register
// mode switch unit. No dependencies.
package brms_pkg;

   // Operation codes carried in the request transaction.
   localparam logic [2:0] OP_READ_REG     = 3'd0;
   localparam logic [2:0] OP_WRITE_REG    = 3'd1;
   localparam logic [2:0] OP_SWITCH_MODE  = 3'd2;
   localparam logic [2:0] OP_TAKE_IRQ     = 3'd3;
   localparam logic [2:0] OP_READ_STATUS  = 3'd4;
   localparam logic [2:0] OP_WRITE_STATUS = 3'd5;
   localparam logic [2:0] OP_READ_SAVED   = 3'd6;
   localparam logic [2:0] OP_WRITE_SAVED  = 3'd7;

   // Processor mode codes.
   localparam logic [4:0] MODE_USR = 5'h10;
   localparam logic [4:0] MODE_FIQ = 5'h11;
   localparam logic [4:0] MODE_IRQ = 5'h12;
   localparam logic [4:0] MODE_SVC = 5'h13;
   localparam logic [4:0] MODE_ABT = 5'h17;
   localparam logic [4:0] MODE_UND = 5'h1B;
   localparam logic [4:0] MODE_SYS = 5'h1F;

   // Bank numbers; NO_BANK marks an invalid mode code.
   localparam logic [2:0] BANK_USR = 3'd0;
   localparam logic [2:0] BANK_FIQ = 3'd1;
   localparam logic [2:0] BANK_IRQ = 3'd2;
   localparam logic [2:0] BANK_SVC = 3'd3;
   localparam logic [2:0] BANK_ABT = 3'd4;
   localparam logic [2:0] BANK_UND = 3'd5;
   localparam logic [2:0] NO_BANK  = 3'd6;
   localparam int         NUM_BANKS = 6;

   // Register file layout.
   localparam int         NUM_REGS   = 16;
   localparam int         HIGH_FIRST = 8;
   localparam int         HIGH_COUNT = 5;
   localparam logic [3:0] REG_SP     = 4'd13;
   localparam logic [3:0] REG_LR     = 4'd14;
   localparam logic [3:0] REG_PC     = 4'd15;

   // Status word bit positions.
   localparam int STATUS_I = 7;
   localparam int STATUS_T = 5;

   // Exception vector offsets and PC adjustment.
   localparam logic [31:0] VEC_FETCH_OFS = 32'h0000_0018;
   localparam logic [31:0] VEC_PC_OFS    = 32'h0000_0020;
   localparam logic [31:0] PC_ADJUST     = 32'h0000_0004;

   typedef logic [2:0]  bank_type;
   typedef logic [4:0]  mode_type;
   typedef logic [31:0] word_type;

   // One request transaction.
   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  reg_index;
      word_type    write_data;
      mode_type    target_mode;
   } cmd_type;

   // One response transaction.
   typedef struct packed {
      word_type    read_data;
      logic        irq_taken;
      word_type    fetch_address;
      logic        bad_mode;
   } result_type;

   // Banked stack pointer and link register of one mode.
   typedef struct packed {
      word_type    sp;
      word_type    lr;
   } sp_lr_type;

   // Map a mode code to its bank.
   function automatic bank_type bank_of(input mode_type mode);
      bank_type b;
      unique case (mode)
         MODE_USR: b = BANK_USR;
         MODE_SYS: b = BANK_USR;
         MODE_FIQ: b = BANK_FIQ;
         MODE_IRQ: b = BANK_IRQ;
         MODE_SVC: b = BANK_SVC;
         MODE_ABT: b = BANK_ABT;
         MODE_UND: b = BANK_UND;
         default:  b = NO_BANK;
      endcase
      return b;
   endfunction

endpackage

@@ rtl/brms_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying one command transaction.
// Depends on nothing but plain widths.
interface brms_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [3:0]  reg_index;
   logic [31:0] write_data;
   logic [4:0]  target_mode;

   modport source (output valid, op, reg_index, write_data, target_mode, input ready);
   modport sink   (input valid, op, reg_index, write_data, target_mode, output ready);
endinterface

@@ rtl/brms_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying one result transaction.
// Depends on nothing but plain widths.
interface brms_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        irq_taken;
   logic [31:0] fetch_address;
   logic        bad_mode;

   modport source (output valid, read_data, irq_taken, fetch_address, bad_mode,
                   input ready);
   modport sink   (input valid, read_data, irq_taken, fetch_address, bad_mode,
                   output ready);
endinterface

@@ rtl/brms_csr_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel for the vector base register.
// Depends on nothing but plain widths.
interface brms_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/brms_exec.sv @@
`timescale 1ns / 1ps
// Architectural state (visible registers, banks, status) and the single-pass
// execute logic for one command. Depends on brms_pkg.
module brms_exec
   import brms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       exec_en,
   input  cmd_type    cmd,
   input  word_type   vector_base,
   output result_type result
);

   word_type   regs_ff   [NUM_REGS];
   word_type   regs_in   [NUM_REGS];
   word_type   fiq_ff    [HIGH_COUNT];
   word_type   fiq_in    [HIGH_COUNT];
   word_type   nrm_ff    [HIGH_COUNT];
   word_type   nrm_in    [HIGH_COUNT];
   sp_lr_type  stk_ff    [NUM_BANKS];
   sp_lr_type  stk_in    [NUM_BANKS];
   word_type   sav_ff    [NUM_BANKS];
   word_type   sav_in    [NUM_BANKS];
   word_type   status_ff;
   word_type   status_in;

   bank_type   cur_bank;
   mode_type   sw_mode;
   bank_type   sw_bank;
   logic       sw_req;
   logic       irq_go;
   sp_lr_type  stk_rd;
   word_type   sav_rd;

   assign cur_bank = bank_of(status_ff[4:0]);
   assign irq_go   = (cmd.op == OP_TAKE_IRQ) && !status_ff[STATUS_I];

   // Target mode of a bank switch, depending on the operation.
   always_comb begin
      unique case (cmd.op)
         OP_WRITE_STATUS: sw_mode = cmd.write_data[4:0];
         OP_TAKE_IRQ:     sw_mode = MODE_IRQ;
         default:         sw_mode = cmd.target_mode;
      endcase
   end

   assign sw_bank = bank_of(sw_mode);
   assign sw_req  = (((cmd.op == OP_SWITCH_MODE) || (cmd.op == OP_WRITE_STATUS))
                     && (sw_bank != NO_BANK)) || irq_go;

   // Bank reads; the current bank is always valid, the guard keeps the index in range.
   assign stk_rd = (sw_bank != NO_BANK) ? stk_ff[sw_bank] : '0;
   assign sav_rd = (cur_bank != NO_BANK) ? sav_ff[cur_bank] : '0;

   // Next state and result for the command.
   always_comb begin
      regs_in   = regs_ff;
      fiq_in    = fiq_ff;
      nrm_in    = nrm_ff;
      stk_in    = stk_ff;
      sav_in    = sav_ff;
      status_in = status_ff;
      result    = '0;

      // Bank switch: swap the FIQ high registers and the stack/link pair.
      if (sw_req) begin
         status_in = {status_ff[31:5], sw_mode};
         if ((sw_bank != cur_bank) && (cur_bank != NO_BANK)) begin
            for (int i = 0; i < HIGH_COUNT; i++) begin
               if (cur_bank == BANK_FIQ) begin
                  fiq_in[i]                     = regs_ff[4'(HIGH_FIRST + i)];
                  regs_in[4'(HIGH_FIRST + i)]   = nrm_ff[i];
               end else if (sw_bank == BANK_FIQ) begin
                  nrm_in[i]                     = regs_ff[4'(HIGH_FIRST + i)];
                  regs_in[4'(HIGH_FIRST + i)]   = fiq_ff[i];
               end
            end
            stk_in[cur_bank] = '{sp: regs_ff[REG_SP], lr: regs_ff[REG_LR]};
            regs_in[REG_SP]  = stk_rd.sp;
            regs_in[REG_LR]  = stk_rd.lr;
         end
      end

      // Operation-specific updates, applied after any bank switch.
      unique case (cmd.op)
         OP_READ_REG: begin
            result.read_data = regs_ff[cmd.reg_index];
         end
         OP_WRITE_REG: begin
            regs_in[cmd.reg_index] = cmd.write_data;
         end
         OP_SWITCH_MODE: begin
            result.bad_mode = (sw_bank == NO_BANK);
         end
         OP_TAKE_IRQ: begin
            if (irq_go) begin
               sav_in[BANK_IRQ] = status_ff;
               status_in = {status_ff[31:8], 1'b1, status_ff[6], 1'b0, MODE_IRQ};
               regs_in[REG_LR] = status_ff[STATUS_T] ? regs_ff[REG_PC]
                                                     : regs_ff[REG_PC] - PC_ADJUST;
               regs_in[REG_PC] = vector_base + VEC_PC_OFS;
               result.irq_taken     = 1'b1;
               result.fetch_address = vector_base + VEC_FETCH_OFS;
            end
         end
         OP_READ_STATUS: begin
            result.read_data = status_ff;
         end
         OP_WRITE_STATUS: begin
            if (sw_bank == NO_BANK) begin
               result.bad_mode = 1'b1;
            end else begin
               status_in = cmd.write_data;
            end
         end
         OP_READ_SAVED: begin
            result.read_data = sav_rd;
         end
         OP_WRITE_SAVED: begin
            if (cur_bank != NO_BANK) begin
               sav_in[cur_bank] = cmd.write_data;
            end
         end
         default: begin
         end
      endcase
   end

   // State registers, committed once per executed command.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
         for (int i = 0; i < HIGH_COUNT; i++) begin
            fiq_ff[i] <= '0;
            nrm_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_BANKS; i++) begin
            stk_ff[i] <= '0;
            sav_ff[i] <= '0;
         end
         status_ff <= {27'd0, MODE_SVC};
      end else if (exec_en) begin
         regs_ff   <= regs_in;
         fiq_ff    <= fiq_in;
         nrm_ff    <= nrm_in;
         stk_ff    <= stk_in;
         sav_ff    <= sav_in;
         status_ff <= status_in;
      end
   end

endmodule

@@ rtl/banked_register_mode_switch_unit.sv @@
`timescale 1ns / 1ps
// Banked register mode switch unit: ARM-style banked register file with mode
// switching and IRQ entry. Depends on brms_pkg, the channel interfaces and brms_exec.
//
// Usage:
//  - req_bus carries one command per transaction (read/write register, switch
//    mode, take IRQ, read/write status, read/write saved status).
//  - rsp_bus returns exactly one result transaction per command, in order.
//  - csr_bus writes the exception vector base; it is always ready and should
//    only be written while no command is in flight.
//  - A command is captured in an input register, then executed in one pass
//    and written into the result register, which drives rsp_bus.valid.
//    One command per cycle is sustained while the receiver takes results;
//    the single execute pass against the register state sets that figure.
//  - Reset clears all registers and banks, selects supervisor mode and
//    clears the vector base.
//  - When the receiver stalls, the result register holds its transaction and
//    the input register buffers one more command; req_bus.ready then drops.
module banked_register_mode_switch_unit
   import brms_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   brms_req_if.sink   req_bus,
   brms_rsp_if.source rsp_bus,
   brms_csr_if.sink   csr_bus
);

   logic       in_valid_ff;
   cmd_type    in_cmd_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   word_type   vector_base_ff;
   logic       exec_en;
   result_type exec_result;

   // Execute when the result register is free or being drained.
   assign exec_en       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || exec_en;
   assign csr_bus.ready = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_cmd_ff <= '{op: req_bus.op, reg_index: req_bus.reg_index,
                        write_data: req_bus.write_data, target_mode: req_bus.target_mode};
      end
   end

   // Vector base configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vector_base_ff <= '0;
      end else if (csr_bus.valid) begin
         vector_base_ff <= csr_bus.data;
      end
   end

   brms_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .exec_en     (exec_en),
      .cmd         (in_cmd_ff),
      .vector_base (vector_base_ff),
      .result      (exec_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_en) begin
         rsp_data_ff <= exec_result;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.read_data     = rsp_data_ff.read_data;
   assign rsp_bus.irq_taken     = rsp_data_ff.irq_taken;
   assign rsp_bus.fetch_address = rsp_data_ff.fetch_address;
   assign rsp_bus.bad_mode      = rsp_data_ff.bad_mode;

   // An executed command always leaves a result in the output register.
   a_exec_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_en |=> rsp_valid_ff)
      else $error("executed command did not produce a result");

   // A result is never both an IRQ entry and a bad mode report.
   a_irq_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.irq_taken && rsp_data_ff.bad_mode))
      else $error("result flags both irq_taken and bad_mode");

   // A fetch address appears only with an IRQ entry.
   a_fetch_only_on_irq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.irq_taken) |-> (rsp_data_ff.fetch_address == '0))
      else $error("fetch address without IRQ entry");

   // Backpressure on the request side only while a command is buffered.
   a_ready_low_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (in_valid_ff && rsp_valid_ff && !rsp_bus.ready))
      else $error("request side stalled without a buffered command");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for banked_register_mode_switch_unit: random and directed commands
// checked against a scoreboard that tracks the banked register state.
// Depends on brms_pkg and the brms_req_if, brms_rsp_if and brms_csr_if interfaces.
module tb_top;
   import brms_pkg::*;

   // Scoreboard: tracks the register banks and status, and holds the results still owed.
   class regfile_scoreboard;
      word_type   regs [NUM_REGS];
      word_type   fiq_high [HIGH_COUNT];
      word_type   usr_high [HIGH_COUNT];
      sp_lr_type  sp_lr [NUM_BANKS];
      word_type   saved_status [NUM_BANKS];
      word_type   status;
      word_type   vector_base;
      result_type owed_results [$];
      int         errors;
      int         checked;
      int         irq_entries;
      int         rejected_modes;

      function new();
         clear();
      endfunction

      // State after reset: everything zero, supervisor mode.
      function void clear();
         foreach (regs[i]) regs[i] = '0;
         foreach (fiq_high[i]) begin
            fiq_high[i] = '0;
            usr_high[i] = '0;
         end
         foreach (sp_lr[i]) begin
            sp_lr[i] = '0;
            saved_status[i] = '0;
         end
         status = {27'd0, MODE_SVC};
         vector_base = '0;
      endfunction

      function bank_type mode_bank(mode_type m);
         case (m)
            MODE_USR, MODE_SYS: return BANK_USR;
            MODE_FIQ:           return BANK_FIQ;
            MODE_IRQ:           return BANK_IRQ;
            MODE_SVC:           return BANK_SVC;
            MODE_ABT:           return BANK_ABT;
            MODE_UND:           return BANK_UND;
            default:            return NO_BANK;
         endcase
      endfunction

      // Swap the outgoing mode's banked registers out and the incoming mode's in.
      function void change_mode(mode_type m);
         bank_type src;
         bank_type dst;
         src = mode_bank(status[4:0]);
         dst = mode_bank(m);
         status[4:0] = m;
         if (src == dst || src == NO_BANK || dst == NO_BANK) return;
         if (src == BANK_FIQ) begin
            for (int i = 0; i < HIGH_COUNT; i++) begin
               fiq_high[i] = regs[HIGH_FIRST + i];
               regs[HIGH_FIRST + i] = usr_high[i];
            end
         end else if (dst == BANK_FIQ) begin
            for (int i = 0; i < HIGH_COUNT; i++) begin
               usr_high[i] = regs[HIGH_FIRST + i];
               regs[HIGH_FIRST + i] = fiq_high[i];
            end
         end
         sp_lr[src].sp = regs[REG_SP];
         sp_lr[src].lr = regs[REG_LR];
         regs[REG_SP] = sp_lr[dst].sp;
         regs[REG_LR] = sp_lr[dst].lr;
      endfunction

      // Apply one accepted command and queue the result it must produce.
      function void note_request(cmd_type c);
         result_type r;
         bank_type   b;
         r = '0;
         case (c.op)
            OP_READ_REG:  r.read_data = regs[c.reg_index];
            OP_WRITE_REG: regs[c.reg_index] = c.write_data;
            OP_SWITCH_MODE: begin
               if (mode_bank(c.target_mode) == NO_BANK) r.bad_mode = 1'b1;
               else change_mode(c.target_mode);
            end
            OP_TAKE_IRQ: begin
               if (!status[STATUS_I]) begin
                  saved_status[BANK_IRQ] = status;
                  change_mode(MODE_IRQ);
                  status[STATUS_I] = 1'b1;
                  if (status[STATUS_T]) begin
                     status[STATUS_T] = 1'b0;
                     regs[REG_LR] = regs[REG_PC];
                  end else begin
                     regs[REG_LR] = regs[REG_PC] - PC_ADJUST;
                  end
                  r.fetch_address = vector_base + VEC_FETCH_OFS;
                  regs[REG_PC] = vector_base + VEC_PC_OFS;
                  r.irq_taken = 1'b1;
               end
            end
            OP_READ_STATUS: r.read_data = status;
            OP_WRITE_STATUS: begin
               if (mode_bank(c.write_data[4:0]) == NO_BANK) begin
                  r.bad_mode = 1'b1;
               end else begin
                  change_mode(c.write_data[4:0]);
                  status = c.write_data;
               end
            end
            OP_READ_SAVED: begin
               b = mode_bank(status[4:0]);
               if (b != NO_BANK) r.read_data = saved_status[b];
            end
            default: begin
               b = mode_bank(status[4:0]);
               if (b != NO_BANK) saved_status[b] = c.write_data;
            end
         endcase
         if (r.irq_taken) irq_entries++;
         if (r.bad_mode) rejected_modes++;
         owed_results.push_back(r);
      endfunction

      function void compare_field(string field, word_type exp_val, word_type act_val);
         if (act_val !== exp_val) begin
            $error("%s mismatch: expected %h, actual %h", field, exp_val, act_val);
            errors++;
         end
      endfunction

      // Compare one accepted response with the oldest owed result.
      function void check_result(result_type got);
         result_type exp_r;
         if (owed_results.size() == 0) begin
            $error("response transaction with no command outstanding");
            errors++;
            return;
         end
         exp_r = owed_results.pop_front();
         checked++;
         compare_field("read_data", exp_r.read_data, got.read_data);
         compare_field("irq_taken", exp_r.irq_taken, got.irq_taken);
         compare_field("fetch_address", exp_r.fetch_address, got.fetch_address);
         compare_field("bad_mode", exp_r.bad_mode, got.bad_mode);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   brms_req_if req_bus ();
   brms_rsp_if rsp_bus ();
   brms_csr_if csr_bus ();

   banked_register_mode_switch_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   regfile_scoreboard sb = new();
   mode_type legal_modes [7] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
                                 MODE_ABT, MODE_UND, MODE_SYS};
   bit want_long_hold = 1'b0;
   int base_writes = 0;

   always #4 clock = ~clock;

   // Give up if the run hangs.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Response side: check every transaction and stall on a pattern that shifts over time.
   initial begin : response_side
      int cycle;
      int hold_left;
      result_type got;
      cycle = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.read_data     = rsp_bus.read_data;
            got.irq_taken     = rsp_bus.irq_taken;
            got.fetch_address = rsp_bus.fetch_address;
            got.bad_mode      = rsp_bus.bad_mode;
            sb.check_result(got);
         end
         cycle++;
         if (want_long_hold) begin
            want_long_hold = 1'b0;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case ((cycle / 200) % 4)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= $urandom_range(0, 1);
               2: rsp_bus.ready <= (cycle % 5) >= 2;
               default: rsp_bus.ready <= $urandom_range(0, 9) != 0;
            endcase
         end
      end
   end

   function automatic cmd_type make_cmd(logic [2:0] op, logic [3:0] idx, word_type data,
                                        mode_type m);
      cmd_type c;
      c.op = op;
      c.reg_index = idx;
      c.write_data = data;
      c.target_mode = m;
      return c;
   endfunction

   // Random command, biased toward legal modes so the banks get exercised.
   function automatic cmd_type random_cmd();
      cmd_type c;
      int pick;
      pick = $urandom_range(0, 99);
      c.reg_index = $urandom_range(0, 15);
      c.write_data = $urandom();
      c.target_mode = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                  : legal_modes[$urandom_range(0, 6)];
      if (pick < 20) begin
         c.op = OP_READ_REG;
      end else if (pick < 40) begin
         c.op = OP_WRITE_REG;
         // Small values make the link register arithmetic wrap.
         if ($urandom_range(0, 9) == 0) c.write_data = $urandom_range(0, 7);
      end else if (pick < 55) begin
         c.op = OP_SWITCH_MODE;
      end else if (pick < 65) begin
         c.op = OP_TAKE_IRQ;
      end else if (pick < 73) begin
         c.op = OP_READ_STATUS;
      end else if (pick < 85) begin
         c.op = OP_WRITE_STATUS;
         if ($urandom_range(0, 6) != 0) c.write_data[4:0] = legal_modes[$urandom_range(0, 6)];
      end else if (pick < 92) begin
         c.op = OP_READ_SAVED;
      end else begin
         c.op = OP_WRITE_SAVED;
      end
      return c;
   endfunction

   // Offer one command and hold it until the block takes it.
   task automatic send_cmd(cmd_type c);
      req_bus.valid       <= 1'b1;
      req_bus.op          <= c.op;
      req_bus.reg_index   <= c.reg_index;
      req_bus.write_data  <= c.write_data;
      req_bus.target_mode <= c.target_mode;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(c);
   endtask

   task automatic pause_requests(int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop offering, wait for every owed result, then let the pipeline settle.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_vector_base(word_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.vector_base = value;
      base_writes++;
      csr_bus.valid <= 1'b0;
   endtask

   // Corner cases: IRQ entry with PC wrap, masked IRQ, FIQ banking, illegal
   // modes, thumb IRQ entry, saved status in user mode, same-bank switch.
   task automatic run_directed();
      send_cmd(make_cmd(OP_READ_STATUS, 4'd0, 32'd0, 5'd0));
      send_cmd(make_cmd(OP_READ_REG, REG_PC, 32'd0, 5'd0));
      send_cmd(make_cmd(OP_WRITE_REG, REG_PC, 32'd2, 5'd0));
      send_cmd(make_cmd(OP_TAKE_IRQ, 4'd0, 32'd0, 5'd0));
      send_cmd(make_cmd(OP_TAKE_IRQ, 4'd0, 32'd0, 5'd0));
      send_cmd(make_cmd(OP_READ_SAVED, 4'd0, 32'd0, 5'd0));
      send_cmd(make_cmd(OP_READ_REG, REG_LR, 32'd0, 5'd0));
      send_cmd(make_cmd(OP_WRITE_REG, 4'd8, 32'hFFFF_FFFF, 5'd0));
      send_cmd(make_cmd(OP_SWITCH_MODE, 4'd0, 32'd0, MODE_FIQ));
      send_cmd(make_cmd(OP_READ_REG, 4'd8, 32'd0, 5'd0));
      send_cmd(make_cmd(OP_WRITE_REG, 4'd12, 32'h8000_0001, 5'd0));
      send_cmd(make_cmd(OP_SWITCH_MODE, 4'd0, 32'd0, 5'h00));
      send_cmd(make_cmd(OP_SWITCH_MODE, 4'd0, 32'd0, 5'h14));
      send_cmd(make_cmd(OP_WRITE_STATUS, 4'd0, 32'hFFFF_FF0E, 5'd0));
      send_cmd(make_cmd(OP_WRITE_STATUS, 4'd0, 32'hF000_0030, 5'd0));
      send_cmd(make_cmd(OP_READ_REG, 4'd8, 32'd0, 5'd0));
      send_cmd(make_cmd(OP_WRITE_SAVED, 4'd0, 32'hDEAD_BEEF, 5'd0));
      send_cmd(make_cmd(OP_READ_SAVED, 4'd0, 32'd0, 5'd0));
      send_cmd(make_cmd(OP_SWITCH_MODE, 4'd0, 32'd0, MODE_SYS));
      send_cmd(make_cmd(OP_READ_STATUS, 4'd0, 32'd0, 5'd0));
      send_cmd(make_cmd(OP_TAKE_IRQ, 4'd0, 32'd0, 5'd0));
      send_cmd(make_cmd(OP_READ_REG, REG_LR, 32'd0, 5'd0));
      send_cmd(make_cmd(OP_SWITCH_MODE, 4'd0, 32'd0, MODE_ABT));
      send_cmd(make_cmd(OP_SWITCH_MODE, 4'd0, 32'd0, MODE_UND));
      send_cmd(make_cmd(OP_SWITCH_MODE, 4'd0, 32'd0, MODE_SVC));
      send_cmd(make_cmd(OP_READ_REG, REG_SP, 32'd0, 5'd0));
   endtask

   // Random commands in bursts; optionally stall the response side midway
   // while a long burst keeps coming, so the block backs up.
   task automatic run_random(int count, bit with_hold);
      int burst_left;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 2) begin
            want_long_hold = 1'b1;
            burst_left = 40;
         end else if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0) begin
               burst_left = $urandom_range(20, 60);
            end else begin
               pause_requests($urandom_range(1, 8));
               burst_left = $urandom_range(1, 16);
            end
         end
         send_cmd(random_cmd());
         burst_left--;
      end
   endtask

   // Main sequence: reset, directed checks, then random phases at several vector bases.
   initial begin
      req_bus.valid       <= 1'b0;
      req_bus.op          <= OP_READ_REG;
      req_bus.reg_index   <= '0;
      req_bus.write_data  <= '0;
      req_bus.target_mode <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.data        <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_vector_base(32'h0000_0000);
      run_directed();
      wait_for_results();
      write_vector_base(32'hFFFF_0000);
      run_random(250, 1'b1);
      wait_for_results();
      write_vector_base(32'hFFFF_FFFF);
      run_random(250, 1'b0);
      wait_for_results();
      write_vector_base($urandom());
      run_random(400, 1'b0);
      wait_for_results();
      $display("Checked %0d response transactions: %0d IRQ entries, %0d illegal mode codes.",
               sb.checked, sb.irq_entries, sb.rejected_modes);
      $display("Vector base was programmed %0d times, including all-zero and all-one values.",
               base_writes);
      if (sb.errors == 0 && sb.owed_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
